>>> rtl/ale_pkg.sv
// ale_pkg: shared constants, command and status codes, request/response types
// for the array list engine. No dependencies.
package ale_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 6;
   localparam int LEN_W    = 6;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [3:0] {
      CMD_READ         = 4'd0,
      CMD_WRITE        = 4'd1,
      CMD_INSERT_FRONT = 4'd2,
      CMD_INSERT_BACK  = 4'd3,
      CMD_INSERT_AT    = 4'd4,
      CMD_REMOVE_FRONT = 4'd5,
      CMD_REMOVE_BACK  = 4'd6,
      CMD_REMOVE_AT    = 4'd7,
      CMD_SEARCH       = 4'd8,
      CMD_CLEAR        = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [3:0]        cmd;
      logic [POS_W-1:0]  position;
      logic signed [31:0] entry_key;
      logic [31:0]       entry_payload;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_key;
      logic [31:0]        out_payload;
      logic               found;
      logic [LEN_W-1:0]   list_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

>>> rtl/ale_ctrl.sv
// ale_ctrl: two-state controller sequencing request capture and execution.
// Depends on ale_pkg.
module ale_ctrl
   import ale_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            busy      = 1'b1;
            ctrl.exec = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/ale_dpath.sv
// ale_dpath: entry store, length counter, parallel key compare, shift network
// and response register. Depends on ale_pkg.
module ale_dpath
   import ale_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type ctrl,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   entry_type            store_ff [CAPACITY];
   entry_type            store_in [CAPACITY];
   logic [CNT_W-1:0]     count_ff, count_in;
   req_type              req_ff;
   logic [CAPACITY-1:0]  match_ff, match_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic [IDX_W-1:0]     pos_idx, tgt;
   logic                 pos_ok, full, empty, found_any;
   logic [CAPACITY-1:0]  occ;
   entry_type            sel_entry, new_entry;

   // compare the incoming key against every slot while the request is taken
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (store_ff[i].key == req_data.entry_key);
         occ[i]      = (CNT_W'(i) < count_ff);
      end
   end

   always_comb begin
      pos_idx = IDX_W'(req_ff.position - POS_W'(1));
      case (req_ff.cmd)
         CMD_INSERT_FRONT,
         CMD_REMOVE_FRONT: tgt = '0;
         CMD_INSERT_BACK:  tgt = IDX_W'(count_ff);
         CMD_REMOVE_BACK:  tgt = IDX_W'(count_ff - CNT_W'(1));
         default:          tgt = pos_idx;
      endcase
   end

   assign sel_entry = store_ff[tgt];
   assign new_entry = '{key: req_ff.entry_key, payload: req_ff.entry_payload};
   assign pos_ok    = (req_ff.position != '0) &&
                      (CMP_W'(req_ff.position) <= CMP_W'(count_ff));
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign found_any = |(match_ff & occ);

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      rsp_in   = '0;
      case (req_ff.cmd)
         CMD_READ: begin
            if (!pos_ok) begin
               rsp_in.status = STATUS_BADPOS;
            end else begin
               rsp_in.out_key     = sel_entry.key;
               rsp_in.out_payload = sel_entry.payload;
            end
         end
         CMD_WRITE: begin
            if (!pos_ok) begin
               rsp_in.status = STATUS_BADPOS;
            end else begin
               store_in[tgt] = new_entry;
            end
         end
         CMD_INSERT_FRONT, CMD_INSERT_BACK, CMD_INSERT_AT: begin
            if (full) begin
               rsp_in.status = STATUS_FULL;
            end else if ((req_ff.cmd == CMD_INSERT_AT) && !pos_ok) begin
               rsp_in.status = STATUS_BADPOS;
            end else begin
               // open a gap: move every slot from the target on up by one
               for (int i = 1; i < CAPACITY; i++) begin
                  if (IDX_W'(i) > tgt) begin
                     store_in[i] = store_ff[i-1];
                  end
               end
               store_in[tgt] = new_entry;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE_FRONT, CMD_REMOVE_BACK, CMD_REMOVE_AT: begin
            if (empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else if ((req_ff.cmd == CMD_REMOVE_AT) && !pos_ok) begin
               rsp_in.status = STATUS_BADPOS;
            end else begin
               rsp_in.out_key     = sel_entry.key;
               rsp_in.out_payload = sel_entry.payload;
               // close the gap: move every slot above the target down by one
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (IDX_W'(i) >= tgt) begin
                     store_in[i] = store_ff[i+1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_SEARCH: begin
            rsp_in.out_key = '1;
            if (empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else if (found_any) begin
               rsp_in.out_key = req_ff.entry_key;
               rsp_in.found   = 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      rsp_in.list_length = LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff   <= req_data;
         match_ff <= match_in;
      end
      if (ctrl.exec) begin
         store_ff <= store_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.exec;
         if (ctrl.exec) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/array_list_engine.sv
// array_list_engine: top level of the ordered list engine.
// Depends on ale_pkg, ale_ctrl and ale_dpath.
//
// The engine keeps an ordered list of up to CAPACITY (32) key/payload
// entries addressed by 1-based position, and runs one command per request:
// read, write, insert front/back/at, remove front/back/at, search, clear.
// A request is taken on a clock edge where start is high and busy is low.
// For each request, the edge that takes it also compares the
// search key against every slot in parallel, and the next edge (busy high
// in between) executes the command in one step, shifting all slots up or
// down at once through the per-slot shift muxes. The response is then
// registered onto rsp_data and flagged by rsp_valid for exactly one cycle;
// there is no way to hold it, so the receiver must take it in that cycle. busy
// is already low during that response cycle, so the next request can be
// taken there. Every request gets exactly one response. No clearing pass
// is needed after reset: the length counter resets to zero and only occupied
// slots are ever read.
module array_list_engine
   import ale_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_cmd_type ctrl;

   // sequence capture and execution
   ale_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // hold the list, shift, compare and register the response
   ale_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for the array list engine; drives list commands and
// compares every response with a predicted list state. Depends on ale_pkg and
// array_list_engine.
`timescale 1ns / 100ps

module tb_top
   import ale_pkg::*;
();

   // Command codes the block has no name for; it must treat them as no-ops.
   localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
   localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

   // Biases of the random command mix.
   localparam int MODE_GROW   = 0;
   localparam int MODE_MIX    = 1;
   localparam int MODE_SHRINK = 2;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int DRAIN_GUARD     = 4000;

   // Mirror of the list: applies each accepted request and queues the response
   // the block owes for it.
   class list_scoreboard;
      entry_type   slots[CAPACITY];
      int unsigned count;
      rsp_type     expected_q[$];
      int unsigned errors;

      function new();
         count  = 0;
         errors = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         bit          pos_ok;
         int unsigned idx;
         int unsigned i;
         e      = '0;
         e.status = STATUS_OK;
         pos_ok = (r.position >= 1) && (r.position <= count);
         idx    = r.position - 1;
         case (r.cmd)
            CMD_READ: begin
               if (!pos_ok) e.status = STATUS_BADPOS;
               else begin
                  e.out_key     = slots[idx].key;
                  e.out_payload = slots[idx].payload;
               end
            end
            CMD_WRITE: begin
               if (!pos_ok) e.status = STATUS_BADPOS;
               else begin
                  slots[idx].key     = r.entry_key;
                  slots[idx].payload = r.entry_payload;
               end
            end
            CMD_INSERT_FRONT, CMD_INSERT_BACK, CMD_INSERT_AT: begin
               // Full wins over a bad position.
               if (count >= CAPACITY) e.status = STATUS_FULL;
               else if (r.cmd == CMD_INSERT_AT && !pos_ok) e.status = STATUS_BADPOS;
               else begin
                  if (r.cmd == CMD_INSERT_FRONT) idx = 0;
                  else if (r.cmd == CMD_INSERT_BACK) idx = count;
                  for (i = count; i > idx; i--) slots[i] = slots[i-1];
                  slots[idx].key     = r.entry_key;
                  slots[idx].payload = r.entry_payload;
                  count++;
               end
            end
            CMD_REMOVE_FRONT, CMD_REMOVE_BACK, CMD_REMOVE_AT: begin
               // Empty wins over a bad position.
               if (count == 0) e.status = STATUS_EMPTY;
               else if (r.cmd == CMD_REMOVE_AT && !pos_ok) e.status = STATUS_BADPOS;
               else begin
                  if (r.cmd == CMD_REMOVE_FRONT) idx = 0;
                  else if (r.cmd == CMD_REMOVE_BACK) idx = count - 1;
                  e.out_key     = slots[idx].key;
                  e.out_payload = slots[idx].payload;
                  for (i = idx + 1; i < count; i++) slots[i-1] = slots[i];
                  count--;
               end
            end
            CMD_SEARCH: begin
               e.out_key = -1;
               if (count == 0) e.status = STATUS_EMPTY;
               else begin
                  for (i = 0; i < count; i++) begin
                     if (e.found == 1'b0 && slots[i].key == r.entry_key) begin
                        e.out_key = r.entry_key;
                        e.found   = 1'b1;
                     end
                  end
               end
            end
            CMD_CLEAR: count = 0;
            default: ;
         endcase
         e.list_length = count[LEN_W-1:0];
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%08h actual 0x%08h",
                     $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no request pending: expected none actual 0x%h",
                     $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("status",      32'(e.status),      32'(got.status));
         compare_field("out_key",     e.out_key,          got.out_key);
         compare_field("out_payload", e.out_payload,      got.out_payload);
         compare_field("found",       32'(e.found),       32'(got.found));
         compare_field("list_length", 32'(e.list_length), 32'(got.list_length));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   list_scoreboard sb;

   array_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (every request after a long gap).
   initial begin
      #5_000_000;
      $display("FAIL array_list_engine");
      $finish;
   end

   // Sample at the rising edge, before the block's own updates land. Note an
   // accepted request first so the queue stays in issue order, then check any
   // response that closes this cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_valid) sb.check_response(rsp_data);
      end
   end

   // Hold the request on the port until the block takes it.
   task automatic send_request(req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and scramble the idle payload, which must be ignored.
   task automatic idle_cycles(int n);
      logic [95:0] junk;
      repeat (n) begin
         junk = {$urandom, $urandom, $urandom};
         @(negedge clock);
         start    <= 1'b0;
         req_data <= junk[$bits(req_type)-1:0];
      end
   endtask

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic issue(logic [3:0] cmd, logic [5:0] pos, logic [31:0] key,
                        logic [31:0] pay, bit gaps);
      req_type r;
      r.cmd           = cmd;
      r.position      = pos;
      r.entry_key     = key;
      r.entry_payload = pay;
      send_request(r);
      if (gaps) idle_cycles(pick_gap());
   endtask

   // Stall new requests until every response is back; give up after a bound
   // and count whatever is still owed.
   task automatic wait_drained();
      int guard;
      guard = 0;
      while (sb.pending() > 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending() > 0) begin
         $display("%0t: %0d responses never arrived: expected %0d actual 0",
                  $time, sb.pending(), sb.pending());
         sb.errors += sb.pending();
         sb.expected_q.delete();
      end
   endtask

   function automatic logic [3:0] pick_cmd(int mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         MODE_GROW: begin
            if (r < 22) return CMD_INSERT_FRONT;
            if (r < 44) return CMD_INSERT_BACK;
            if (r < 66) return CMD_INSERT_AT;
            if (r < 72) return CMD_REMOVE_AT;
            if (r < 80) return CMD_READ;
            if (r < 88) return CMD_WRITE;
            return CMD_SEARCH;
         end
         MODE_SHRINK: begin
            if (r < 22) return CMD_REMOVE_FRONT;
            if (r < 44) return CMD_REMOVE_BACK;
            if (r < 66) return CMD_REMOVE_AT;
            if (r < 72) return CMD_INSERT_AT;
            if (r < 80) return CMD_READ;
            if (r < 88) return CMD_WRITE;
            return CMD_SEARCH;
         end
         default: begin
            if (r < 2) return CMD_CLEAR;
            if (r < 5) return 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            return 4'($urandom_range(CMD_SEARCH, CMD_READ));
         end
      endcase
   endfunction

   // Mostly a live position, sometimes just past the end, zero, or anything.
   function automatic logic [5:0] pick_position(int len);
      int r;
      r = $urandom_range(99);
      if (len > 0 && r < 75) return 6'($urandom_range(len, 1));
      if (r < 84) return 6'(len + 1);
      if (r < 92) return '0;
      return 6'($urandom_range(63));
   endfunction

   // Keep keys in a narrow band most of the time so searches hit.
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 32'(int'($urandom_range(7)) - 3);
      if (r < 60) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic run_phase(int mode, int n, bit gaps);
      repeat (n)
         issue(pick_cmd(mode), pick_position(sb.count), pick_key(), $urandom, gaps);
   endtask

   initial begin
      int phase;
      sb       = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: error paths on an empty list.
      issue(CMD_READ,         6'd1,  32'd0, 32'd0, 1);
      issue(CMD_WRITE,        6'd0,  32'd5, 32'd5, 1);
      issue(CMD_REMOVE_FRONT, 6'd0,  32'd0, 32'd0, 1);
      issue(CMD_REMOVE_BACK,  6'd0,  32'd0, 32'd0, 1);
      issue(CMD_REMOVE_AT,    6'd0,  32'd0, 32'd0, 1);   // empty beats bad position
      issue(CMD_SEARCH,       6'd0,  32'hFFFF_FFFF, 32'd0, 1);
      issue(CMD_INSERT_AT,    6'd1,  32'd7, 32'd7, 1);   // insert at cannot append
      issue(CMD_UNUSED_HI,    6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);

      // Build a three-entry list with extreme keys and payloads.
      issue(CMD_INSERT_BACK,  6'd0,  32'h8000_0000, 32'h0000_0000, 1);
      issue(CMD_INSERT_FRONT, 6'd0,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
      issue(CMD_INSERT_AT,    6'd2,  32'hFFFF_FFFF, 32'h5A5A_5A5A, 1);
      issue(CMD_INSERT_AT,    6'd4,  32'd1, 32'd1, 1);   // one past the end
      issue(CMD_READ,         6'd0,  32'd0, 32'd0, 1);
      issue(CMD_READ,         6'd63, 32'd0, 32'd0, 1);
      issue(CMD_READ,         6'd3,  32'd0, 32'd0, 1);
      issue(CMD_WRITE,        6'd1,  32'd0, 32'hA5A5_A5A5, 1);
      issue(CMD_SEARCH,       6'd0,  32'hFFFF_FFFF, 32'd0, 1); // hit on key -1
      issue(CMD_SEARCH,       6'd0,  32'd12345, 32'd0, 1);     // miss
      issue(CMD_REMOVE_AT,    6'd2,  32'd0, 32'd0, 1);
      issue(CMD_REMOVE_AT,    6'd3,  32'd0, 32'd0, 1);
      issue(CMD_REMOVE_FRONT, 6'd0,  32'd0, 32'd0, 1);
      issue(CMD_REMOVE_BACK,  6'd0,  32'd0, 32'd0, 1);
      issue(CMD_INSERT_BACK,  6'd0,  32'd9, 32'd9, 1);
      issue(CMD_CLEAR,        6'd0,  32'd0, 32'd0, 1);
      issue(CMD_UNUSED_LO,    6'd0,  32'd0, 32'd0, 0);
      idle_cycles(1);
      wait_drained();

      // Random: fill past full, churn, drain past empty; pause for all
      // responses between phases, and run every third phase without gaps.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0:       run_phase(MODE_GROW,   ITEMS_PER_PHASE, (phase % 3) != 2);
            2:       run_phase(MODE_SHRINK, ITEMS_PER_PHASE, (phase % 3) != 2);
            default: run_phase(MODE_MIX,    ITEMS_PER_PHASE, (phase % 3) != 2);
         endcase
         idle_cycles(1);
         wait_drained();
      end

      // Leave room for any stray late response to show up.
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS array_list_engine");
      else
         $display("FAIL array_list_engine");
      $finish;
   end

endmodule
